// ===== design/spq_pkg.sv =====
// package: sizes, slot and command types and status codes of the priority queue
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int PRI_BITS    = 4;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic                valid;
        logic [PRI_BITS-1:0] pri;
        logic [TAG_BITS-1:0] tag;
    } t_slot;

    typedef struct packed {
        logic                ins;
        logic                rem;
        logic [PRI_BITS-1:0] pri;
        logic [TAG_BITS-1:0] tag;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/spq_cell.sv =====
// one slot of the sorted queue: holds, takes the new entry, or shifts with a neighbor
`timescale 1ns / 1ps
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cmd  i_cmd,
    input  wire t_slot i_prev,
    input  wire logic  i_prev_stay,
    input  wire t_slot i_next,
    output t_slot      o_slot,
    output logic       o_stay
);

    t_slot r_slot;
    t_slot n_slot;

    assign o_stay = r_slot.valid && (r_slot.pri >= i_cmd.pri);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.ins) begin
            if (!o_stay) begin
                if (i_prev_stay) begin
                    n_slot.valid = 1'b1;
                    n_slot.pri   = i_cmd.pri;
                    n_slot.tag   = i_cmd.tag;
                end else begin
                    n_slot = i_prev;
                end
            end
        end else if (i_cmd.rem) begin
            n_slot = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot.valid <= n_slot.valid;
        end
        r_slot.pri <= n_slot.pri;
        r_slot.tag <= n_slot.tag;
    end

endmodule

`default_nettype wire

// ===== design/stable_priority_queue.sv =====
// top level: stable sorted-insert priority queue built as a row of shifting cells
//
// channel | direction | handshake                | words
// in      | input     | i_in_valid / o_in_ready  | i_operation, i_priority_req, i_entry_tag
// out     | output    | o_out_valid / i_out_ready| o_status, o_removed_priority,
//         |           |                          | o_removed_tag, o_occupancy
//
// one operation per cycle while o_in_ready is high: every cell compares against the new priority at once
// result appears in the output register in the cycle after acceptance
// a waiting result still lets a new word in when i_out_ready is high
// synchronous active-low reset empties the queue; slot contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue import spq_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_operation,
    input  wire logic [3:0]          i_priority_req,
    input  wire logic [15:0]         i_entry_tag,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [1:0]               o_status,
    output logic [3:0]               o_removed_priority,
    output logic [15:0]              o_removed_tag,
    output logic [4:0]               o_occupancy
);

    t_slot                 w_slot [QUEUE_DEPTH];
    logic                  w_stay [QUEUE_DEPTH];
    t_cmd                  w_cmd;
    t_slot                 w_blank;
    logic                  w_accept;
    logic                  w_empty;
    logic                  w_full;
    logic [CNT_BITS-1:0]   r_count;
    logic [CNT_BITS-1:0]   n_count;
    logic                  r_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [PRI_BITS-1:0]   r_rem_pri;
    logic [PRI_BITS-1:0]   n_rem_pri;
    logic [TAG_BITS-1:0]   r_rem_tag;
    logic [TAG_BITS-1:0]   n_rem_tag;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_empty    = !w_slot[0].valid;
    assign w_full     = w_slot[QUEUE_DEPTH-1].valid;

    assign w_blank = '{valid: 1'b0, pri: '0, tag: '0};

    assign w_cmd.ins = w_accept && (t_op'(i_operation) == OP_INSERT) && !w_full;
    assign w_cmd.rem = w_accept && (t_op'(i_operation) == OP_REMOVE) && !w_empty;
    assign w_cmd.pri = i_priority_req;
    assign w_cmd.tag = i_entry_tag;

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            t_slot w_prev;
            t_slot w_next;
            logic  w_prev_stay;
            if (g == 0) begin : g_head
                assign w_prev      = w_blank;
                assign w_prev_stay = 1'b1;
            end else begin : g_body
                assign w_prev      = w_slot[g-1];
                assign w_prev_stay = w_stay[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next = w_blank;
            end else begin : g_mid
                assign w_next = w_slot[g+1];
            end
            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (w_cmd),
                .i_prev      (w_prev),
                .i_prev_stay (w_prev_stay),
                .i_next      (w_next),
                .o_slot      (w_slot[g]),
                .o_stay      (w_stay[g])
            );
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        n_rem_pri = '0;
        n_rem_tag = '0;
        n_status  = ST_INSERTED;
        if (t_op'(i_operation) == OP_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status  = ST_REMOVED;
                n_rem_pri = w_slot[0].pri;
                n_rem_tag = w_slot[0].tag;
                n_count   = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_status  <= n_status;
            r_rem_pri <= n_rem_pri;
            r_rem_tag <= n_rem_tag;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_removed_priority = r_rem_pri;
    assign o_removed_tag      = r_rem_tag;
    assign o_occupancy        = r_count;

endmodule

`default_nettype wire

// ===== design/stable_priority_queue_checker.sv =====
// checker: port-level properties of the priority queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_checker import spq_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_status,
    input wire logic [3:0]  o_removed_priority,
    input wire logic [15:0] o_removed_tag,
    input wire logic [4:0]  o_occupancy
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_occupancy))
        else $error("result dropped while stalled");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_occupancy <= 5'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_FULL) |-> o_occupancy == 5'(QUEUE_DEPTH))
        else $error("full reported below depth");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_EMPTY) |-> o_occupancy == 5'd0)
        else $error("empty reported with entries");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_REMOVED)
            |-> o_removed_priority == 4'd0 && o_removed_tag == 16'd0)
        else $error("removed fields set without a removal");

endmodule

bind stable_priority_queue stable_priority_queue_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_status           (o_status),
    .o_removed_priority (o_removed_priority),
    .o_removed_tag      (o_removed_tag),
    .o_occupancy        (o_occupancy)
);

`default_nettype wire
